// File: src/ps2a_pkg.sv
// Package for the PS/2 set-2 scan code to ASCII decoder.
// Holds scan code constants, the prefix state type, the queue item type and the key table.
// No dependencies.
package ps2a_pkg;

    // Scan codes that steer the prefix and modifier logic, and the backspace code.
    localparam logic [7:0] CODE_E0     = 8'hE0;
    localparam logic [7:0] CODE_F0     = 8'hF0;
    localparam logic [7:0] CODE_LCTRL  = 8'h14;
    localparam logic [7:0] CODE_LSHIFT = 8'h12;
    localparam logic [7:0] CODE_RSHIFT = 8'h59;
    localparam logic [7:0] CODE_CAPS   = 8'h58;
    localparam logic [7:0] CODE_BKSP   = 8'h66;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Prefix tracking state.
    typedef enum logic [1:0] {
        PFX_NONE = 2'd0,
        PFX_E0   = 2'd1,
        PFX_E0F0 = 2'd2,
        PFX_F0   = 2'd3
    } prefix_state_t;

    // A make code waiting for its table lookup, with the modifiers seen at its arrival.
    typedef struct packed {
        logic [7:0] code;
        logic       shift;
        logic       ctrl;
    } key_item_t;

    // Maps a make code to its character; zero means no character.
    function automatic logic [6:0] decode_make(input logic [7:0] code, input logic shift,
                                               input logic ctrl);
        logic [6:0] lo;
        logic [6:0] up;
        logic [6:0] cc;
        logic       ctrl_ok;
        logic       hit;
        lo      = '0;
        up      = '0;
        cc      = '0;
        ctrl_ok = 1'b0;
        hit     = 1'b1;
        case (code)
            8'h15: begin lo = 7'("q"); up = 7'("Q"); cc = 7'h11; ctrl_ok = 1'b1; end
            8'h16: begin lo = 7'("1"); up = 7'("!"); end
            8'h1A: begin lo = 7'("z"); up = 7'("Z"); cc = 7'h1A; ctrl_ok = 1'b1; end
            8'h1B: begin lo = 7'("s"); up = 7'("S"); cc = 7'h13; ctrl_ok = 1'b1; end
            8'h1C: begin lo = 7'("a"); up = 7'("A"); cc = 7'h01; ctrl_ok = 1'b1; end
            8'h1D: begin lo = 7'("w"); up = 7'("W"); cc = 7'h17; ctrl_ok = 1'b1; end
            8'h1E: begin lo = 7'("2"); up = 7'("@"); cc = 7'h00; ctrl_ok = 1'b1; end
            8'h21: begin lo = 7'("c"); up = 7'("C"); cc = 7'h03; ctrl_ok = 1'b1; end
            8'h22: begin lo = 7'("x"); up = 7'("X"); cc = 7'h18; ctrl_ok = 1'b1; end
            8'h23: begin lo = 7'("d"); up = 7'("D"); cc = 7'h04; ctrl_ok = 1'b1; end
            8'h24: begin lo = 7'("e"); up = 7'("E"); cc = 7'h05; ctrl_ok = 1'b1; end
            8'h25: begin lo = 7'("4"); up = 7'("$"); end
            8'h26: begin lo = 7'("3"); up = 7'("#"); end
            8'h29: begin lo = 7'(" "); up = 7'(" "); end
            8'h2A: begin lo = 7'("v"); up = 7'("V"); cc = 7'h16; ctrl_ok = 1'b1; end
            8'h2B: begin lo = 7'("f"); up = 7'("F"); cc = 7'h06; ctrl_ok = 1'b1; end
            8'h2C: begin lo = 7'("t"); up = 7'("T"); cc = 7'h14; ctrl_ok = 1'b1; end
            8'h2D: begin lo = 7'("r"); up = 7'("R"); cc = 7'h12; ctrl_ok = 1'b1; end
            8'h2E: begin lo = 7'("5"); up = 7'("%"); end
            8'h31: begin lo = 7'("n"); up = 7'("N"); cc = 7'h0E; ctrl_ok = 1'b1; end
            8'h32: begin lo = 7'("b"); up = 7'("B"); cc = 7'h02; ctrl_ok = 1'b1; end
            8'h33: begin lo = 7'("h"); up = 7'("H"); cc = 7'h08; ctrl_ok = 1'b1; end
            8'h34: begin lo = 7'("g"); up = 7'("G"); cc = 7'h07; ctrl_ok = 1'b1; end
            8'h35: begin lo = 7'("y"); up = 7'("Y"); cc = 7'h19; ctrl_ok = 1'b1; end
            8'h36: begin lo = 7'("6"); up = 7'("^"); cc = 7'h1E; ctrl_ok = 1'b1; end
            8'h3A: begin lo = 7'("m"); up = 7'("M"); cc = 7'h0D; ctrl_ok = 1'b1; end
            8'h3B: begin lo = 7'("j"); up = 7'("J"); cc = 7'h0A; ctrl_ok = 1'b1; end
            8'h3C: begin lo = 7'("u"); up = 7'("U"); cc = 7'h15; ctrl_ok = 1'b1; end
            8'h3D: begin lo = 7'("7"); up = 7'("&"); end
            8'h3E: begin lo = 7'("8"); up = 7'("*"); end
            8'h41: begin lo = 7'(","); up = 7'("<"); end
            8'h42: begin lo = 7'("k"); up = 7'("K"); cc = 7'h0B; ctrl_ok = 1'b1; end
            8'h43: begin lo = 7'("i"); up = 7'("I"); cc = 7'h09; ctrl_ok = 1'b1; end
            8'h44: begin lo = 7'("o"); up = 7'("O"); cc = 7'h0F; ctrl_ok = 1'b1; end
            8'h45: begin lo = 7'("0"); up = 7'(")"); end
            8'h46: begin lo = 7'("9"); up = 7'("("); end
            8'h49: begin lo = 7'("."); up = 7'(">"); end
            8'h4A: begin lo = 7'("/"); up = 7'("?"); end
            8'h4B: begin lo = 7'("l"); up = 7'("L"); cc = 7'h0C; ctrl_ok = 1'b1; end
            8'h4C: begin lo = 7'(";"); up = 7'(":"); end
            8'h4D: begin lo = 7'("p"); up = 7'("P"); cc = 7'h10; ctrl_ok = 1'b1; end
            8'h4E: begin lo = 7'("-"); up = 7'("_"); cc = 7'h1F; ctrl_ok = 1'b1; end
            8'h52: begin lo = 7'("'"); up = 7'("\""); end
            8'h54: begin lo = 7'("["); up = 7'("{"); cc = 7'h1B; ctrl_ok = 1'b1; end
            8'h55: begin lo = 7'("="); up = 7'("+"); end
            8'h5A: begin lo = 7'h0D; up = 7'h0D; end
            8'h5B: begin lo = 7'("]"); up = 7'("}"); cc = 7'h1D; ctrl_ok = 1'b1; end
            CODE_BKSP: begin lo = 7'h08; up = 7'h08; end
            default: hit = 1'b0;
        endcase
        if (!hit) begin
            return 7'd0;
        end else if (ctrl && ctrl_ok) begin
            return cc;
        end else if (shift) begin
            return up;
        end else begin
            return lo;
        end
    endfunction

endpackage

// File: src/ps2a_front.sv
// Front end of the decoder: takes scan bytes, tracks prefixes and modifier keys.
// Make codes of other keys go out as items for the back end. Uses ps2a_pkg.
module ps2a_front
    import ps2a_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    output logic       item_valid,
    output key_item_t  item
);

    prefix_state_t prefix_reg, prefix_next;
    logic shift_l_reg, shift_l_next;
    logic shift_r_reg, shift_r_next;
    logic ctrl_l_reg, ctrl_l_next;
    logic ctrl_r_reg, ctrl_r_next;
    logic caps_reg, caps_next;
    logic take;

    // Zero bytes are dropped on the spot.
    assign take = in_valid && (in_byte != 8'd0);

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg  <= PFX_NONE;
            shift_l_reg <= 1'b0;
            shift_r_reg <= 1'b0;
            ctrl_l_reg  <= 1'b0;
            ctrl_r_reg  <= 1'b0;
            caps_reg    <= 1'b0;
        end
        else
        begin
            prefix_reg  <= prefix_next;
            shift_l_reg <= shift_l_next;
            shift_r_reg <= shift_r_next;
            ctrl_l_reg  <= ctrl_l_next;
            ctrl_r_reg  <= ctrl_r_next;
            caps_reg    <= caps_next;
        end
    end

    // Prefix and modifier update, and classification of plain make codes.
    always_comb
    begin
        prefix_next  = prefix_reg;
        shift_l_next = shift_l_reg;
        shift_r_next = shift_r_reg;
        ctrl_l_next  = ctrl_l_reg;
        ctrl_r_next  = ctrl_r_reg;
        caps_next    = caps_reg;
        item_valid   = 1'b0;
        item.code    = in_byte;
        item.shift   = caps_reg ^ (shift_l_reg | shift_r_reg);
        item.ctrl    = ctrl_l_reg | ctrl_r_reg;
        if (take)
        begin
            prefix_next = PFX_NONE;
            case (prefix_reg)
                PFX_E0:
                begin
                    if (in_byte == CODE_F0)
                        prefix_next = PFX_E0F0;
                    else if (in_byte == CODE_LCTRL)
                        ctrl_r_next = 1'b1;
                end
                PFX_E0F0:
                begin
                    if (in_byte == CODE_LCTRL)
                        ctrl_r_next = 1'b0;
                end
                PFX_F0:
                begin
                    if (in_byte == CODE_LSHIFT)
                        shift_l_next = 1'b0;
                    else if (in_byte == CODE_RSHIFT)
                        shift_r_next = 1'b0;
                    else if (in_byte == CODE_LCTRL)
                        ctrl_l_next = 1'b0;
                end
                default:
                begin
                    case (in_byte)
                        CODE_E0:     prefix_next  = PFX_E0;
                        CODE_F0:     prefix_next  = PFX_F0;
                        CODE_LSHIFT: shift_l_next = 1'b1;
                        CODE_RSHIFT: shift_r_next = 1'b1;
                        CODE_LCTRL:  ctrl_l_next  = 1'b1;
                        CODE_CAPS:   caps_next    = ~caps_reg;
                        default:     item_valid   = 1'b1;
                    endcase
                end
            endcase
        end
    end

endmodule

// File: src/ps2a_queue.sv
// Short queue of classified key items between the front and the back end.
// Uses ps2a_pkg for the item type and depth.
module ps2a_queue
    import ps2a_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_en,
    input  key_item_t wr_item,
    input  logic      rd_en,
    output logic      full,
    output logic      not_empty,
    output key_item_t rd_item
);

    key_item_t               mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]       count_reg, count_next;
    logic                    do_wr, do_rd;

    assign full      = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_wr     = wr_en && !full;
    assign do_rd     = rd_en && not_empty;
    assign rd_item   = mem[rd_ptr_reg];

    // Storage write.
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_item;
    end

    // Occupancy count.
    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    // Pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

// File: src/ps2a_back.sv
// Back end of the decoder: looks up the character of a queued key item.
// Items with no character are dropped; others wait in the output register. Uses ps2a_pkg.
module ps2a_back
    import ps2a_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  key_item_t  item,
    output logic       item_take,
    input  logic       out_take,
    output logic       out_valid,
    output logic [6:0] out_char
);

    logic [6:0] lookup;
    logic       out_valid_reg, out_valid_next;
    logic [6:0] char_reg;
    logic       load;

    // Table lookup of the head item.
    assign lookup = decode_make(item.code, item.shift, item.ctrl);

    // A zero character is dropped at once; otherwise wait for a free output register.
    assign load      = item_valid && (lookup != 7'd0) && (!out_valid_reg || out_take);
    assign item_take = item_valid && ((lookup == 7'd0) || !out_valid_reg || out_take);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (out_take)
            out_valid_next = 1'b0;
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Output character.
    always_ff @(posedge clk)
    begin
        if (load)
            char_reg <= lookup;
    end

    assign out_valid = out_valid_reg;
    assign out_char  = char_reg;

endmodule

// File: src/ps2_scancode_to_ascii.sv
// Top level of the PS/2 set-2 scan code to ASCII decoder.
// Instantiates ps2a_front, ps2a_queue and ps2a_back; uses ps2a_pkg.
//
// Channel   Ports                      Transfer when
// input     push, full, scan_byte      push && !full
// result    empty, pop, char_code      pop && !empty
//
// One byte may be taken every cycle. The front updates prefix and modifier state
// in the cycle it takes a byte; a plain make code enters the four-entry queue, and
// the back looks it up at the head of the queue and fills the output register once that is free or being popped.
// Items with no character are dropped by the back at one per cycle once they reach the
// head of the queue. When the result side stalls, the queue fills and full rises. Reset
// clears the prefix and modifier state, the queue and the output valid flag.
module ps2_scancode_to_ascii
    import ps2a_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] scan_byte,
    output logic       empty,
    input  logic       pop,
    output logic [6:0] char_code
);

    logic      in_xfer;
    logic      front_valid;
    key_item_t front_item;
    logic      q_not_empty;
    key_item_t q_item;
    logic      q_take;
    logic      out_valid;
    logic      out_xfer;

    assign in_xfer  = push && !full;
    assign out_xfer = pop && out_valid;
    assign empty    = !out_valid;

    // Prefix and modifier tracking.
    ps2a_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_xfer),
        .in_byte    (scan_byte),
        .item_valid (front_valid),
        .item       (front_item)
    );

    // Decoupling queue.
    ps2a_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (front_valid),
        .wr_item   (front_item),
        .rd_en     (q_take),
        .full      (full),
        .not_empty (q_not_empty),
        .rd_item   (q_item)
    );

    // Character lookup and output register.
    ps2a_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (q_not_empty),
        .item       (q_item),
        .item_take  (q_take),
        .out_take   (out_xfer),
        .out_valid  (out_valid),
        .out_char   (char_code)
    );

endmodule

// File: src/ps2a_checker.sv
// Port-level checks for the PS/2 scan code decoder.
// Depends on the ports of ps2_scancode_to_ascii; bound to it below.
module ps2a_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       push,
    input logic       full,
    input logic [7:0] scan_byte,
    input logic       empty,
    input logic       pop,
    input logic [6:0] char_code
);

    // A shown result is never the null character.
    assert property (@(posedge clk) disable iff (!rst_n) !empty |-> (char_code != 7'd0))
        else $error("result shown with a null character");

    // A stalled result stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(char_code)))
        else $error("stalled result changed or vanished");

    // With the output register free, the back drains the queue, so full cannot persist.
    assert property (@(posedge clk) disable iff (!rst_n) (full && empty) |=> !full)
        else $error("queue stays full while the output is free");

    // Full is low right after reset.
    assert property (@(posedge clk) $rose(rst_n) |-> !full)
        else $error("full is high out of reset");

endmodule

bind ps2_scancode_to_ascii ps2a_checker u_ps2a_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .scan_byte (scan_byte),
    .empty     (empty),
    .pop       (pop),
    .char_code (char_code)
);

// File: tb/tb_ps2_scancode_to_ascii.sv
// Self-checking testbench for ps2_scancode_to_ascii, the PS/2 scan code to ASCII decoder.
// Scan bytes are pushed in random bursts; characters are checked against a keyboard model.
// Depends on ps2a_pkg for the scan code constants and the prefix state type.
module tb_ps2_scancode_to_ascii
    import ps2a_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SCAN_ITEMS     = 1950;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 32;
    localparam int MAX_PRINTED    = 40;

    // Patterns that the character reader follows when it pops.
    typedef enum int {
        DRAIN_FREE,
        DRAIN_COIN,
        DRAIN_SPARSE,
        DRAIN_SLOW
    } drain_mode_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] scan_byte = 8'h00;
    logic       empty;
    logic       pop = 1'b0;
    logic [6:0] char_code;

    // Keyboard model state.
    prefix_state_t pfx_now = PFX_NONE;
    bit            lshift_down = 1'b0;
    bit            rshift_down = 1'b0;
    bit            lctrl_down = 1'b0;
    bit            rctrl_down = 1'b0;
    bit            caps_on = 1'b0;

    bit [7:0]    scan_pending[$];
    bit [6:0]    chars_due[$];
    bit [7:0]    key_codes[$];
    int          error_count = 0;
    int          idle_cycles = 0;
    bit          byte_taken = 1'b0;
    int          burst_left = 0;
    int          gap_left = 0;
    drain_mode_t drain_mode = DRAIN_FREE;
    int          drain_left = 0;

    ps2_scancode_to_ascii uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .scan_byte (scan_byte),
        .empty     (empty),
        .pop       (pop),
        .char_code (char_code)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Prints one line for a mismatch and counts it; printing stops after MAX_PRINTED mismatches.
    task automatic report_mismatch(input string msg);
        if (error_count < MAX_PRINTED)
        begin
            $display("%0t: ERROR %s", $realtime, msg);
        end
        error_count++;
    endtask

    // Unshifted character of a key in the table, or zero for any other code.
    function automatic bit [7:0] base_char(input bit [7:0] code);
        case (code)
            8'h15: return "q";
            8'h16: return "1";
            8'h1A: return "z";
            8'h1B: return "s";
            8'h1C: return "a";
            8'h1D: return "w";
            8'h1E: return "2";
            8'h21: return "c";
            8'h22: return "x";
            8'h23: return "d";
            8'h24: return "e";
            8'h25: return "4";
            8'h26: return "3";
            8'h29: return " ";
            8'h2A: return "v";
            8'h2B: return "f";
            8'h2C: return "t";
            8'h2D: return "r";
            8'h2E: return "5";
            8'h31: return "n";
            8'h32: return "b";
            8'h33: return "h";
            8'h34: return "g";
            8'h35: return "y";
            8'h36: return "6";
            8'h3A: return "m";
            8'h3B: return "j";
            8'h3C: return "u";
            8'h3D: return "7";
            8'h3E: return "8";
            8'h41: return ",";
            8'h42: return "k";
            8'h43: return "i";
            8'h44: return "o";
            8'h45: return "0";
            8'h46: return "9";
            8'h49: return ".";
            8'h4A: return "/";
            8'h4B: return "l";
            8'h4C: return ";";
            8'h4D: return "p";
            8'h4E: return "-";
            8'h52: return "'";
            8'h54: return "[";
            8'h55: return "=";
            8'h5A: return 8'h0D;
            8'h5B: return "]";
            CODE_BKSP: return 8'h08;
            default: return 8'h00;
        endcase
    endfunction

    // Shifted form of a non-letter character; space, enter and backspace stay as they are.
    function automatic bit [7:0] shifted_symbol(input bit [7:0] c);
        case (c)
            "1": return "!";
            "2": return "@";
            "3": return "#";
            "4": return "$";
            "5": return "%";
            "6": return "^";
            "7": return "&";
            "8": return "*";
            "9": return "(";
            "0": return ")";
            ",": return "<";
            ".": return ">";
            "/": return "?";
            ";": return ":";
            "-": return "_";
            "'": return "\"";
            "[": return "{";
            "]": return "}";
            "=": return "+";
            default: return c;
        endcase
    endfunction

    // Character of a key press under the given shift and control levels.
    function automatic bit [7:0] key_char(input bit [7:0] code, input bit shifted,
                                          input bit ctl);
        bit [7:0] base;
        bit [7:0] ctl_code;
        bit       ctl_key;
        bit       letter;
        base     = base_char(code);
        letter   = (base >= "a") && (base <= "z");
        ctl_key  = 1'b1;
        ctl_code = 8'h00;
        // Letters give their control code; a few symbol keys have one as well.
        if (letter)
        begin
            ctl_code = base & 8'h1F;
        end
        else
        begin
            case (base)
                "2": ctl_code = 8'h00;
                "6": ctl_code = 8'h1E;
                "-": ctl_code = 8'h1F;
                "[": ctl_code = 8'h1B;
                "]": ctl_code = 8'h1D;
                default: ctl_key = 1'b0;
            endcase
        end
        if (ctl && ctl_key)
        begin
            return ctl_code;
        end
        if (!shifted)
        begin
            return base;
        end
        if (letter)
        begin
            return base ^ 8'h20;
        end
        return shifted_symbol(base);
    endfunction

    // Applies one accepted scan byte to the keyboard model and queues its character.
    task automatic predict_scan(input bit [7:0] code);
        bit [7:0] ch;
        ch = 8'h00;
        if (code != 8'h00)
        begin
            case (pfx_now)
                PFX_E0:
                begin
                    pfx_now = PFX_NONE;
                    if (code == CODE_F0)
                    begin
                        pfx_now = PFX_E0F0;
                    end
                    else if (code == CODE_LCTRL)
                    begin
                        rctrl_down = 1'b1;
                    end
                end
                PFX_E0F0:
                begin
                    pfx_now = PFX_NONE;
                    if (code == CODE_LCTRL)
                    begin
                        rctrl_down = 1'b0;
                    end
                end
                PFX_F0:
                begin
                    // A caps lock release changes nothing.
                    pfx_now = PFX_NONE;
                    if (code == CODE_LSHIFT)
                    begin
                        lshift_down = 1'b0;
                    end
                    else if (code == CODE_RSHIFT)
                    begin
                        rshift_down = 1'b0;
                    end
                    else if (code == CODE_LCTRL)
                    begin
                        lctrl_down = 1'b0;
                    end
                end
                default:
                begin
                    if (code == CODE_E0)
                    begin
                        pfx_now = PFX_E0;
                    end
                    else if (code == CODE_F0)
                    begin
                        pfx_now = PFX_F0;
                    end
                    else if (code == CODE_LSHIFT)
                    begin
                        lshift_down = 1'b1;
                    end
                    else if (code == CODE_RSHIFT)
                    begin
                        rshift_down = 1'b1;
                    end
                    else if (code == CODE_LCTRL)
                    begin
                        lctrl_down = 1'b1;
                    end
                    else if (code == CODE_CAPS)
                    begin
                        caps_on = !caps_on;
                    end
                    else
                    begin
                        ch = key_char(code, caps_on ^ (lshift_down | rshift_down),
                                      lctrl_down | rctrl_down);
                    end
                end
            endcase
        end
        if (ch != 8'h00)
        begin
            chars_due.push_back(ch[6:0]);
        end
    endtask

    // One of the modifier keys, picked at random.
    function automatic bit [7:0] random_modifier();
        case ($urandom_range(0, 3))
            0: return CODE_LSHIFT;
            1: return CODE_RSHIFT;
            2: return CODE_LCTRL;
            default: return CODE_CAPS;
        endcase
    endfunction

    // Queues one keyboard event: mostly well-formed makes and breaks, some noise.
    task automatic queue_key_event();
        int       pick;
        bit [7:0] key;
        pick = $urandom_range(0, 99);
        key  = key_codes[$urandom_range(0, key_codes.size() - 1)];
        if (pick < 45)
        begin
            scan_pending.push_back(key);
        end
        else if (pick < 57)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                scan_pending.push_back(CODE_E0);
                scan_pending.push_back(CODE_LCTRL);
            end
            else
            begin
                scan_pending.push_back(random_modifier());
            end
        end
        else if (pick < 73)
        begin
            scan_pending.push_back(CODE_F0);
            scan_pending.push_back(($urandom_range(0, 1) == 0) ? random_modifier() : key);
        end
        else if (pick < 81)
        begin
            scan_pending.push_back(CODE_E0);
            scan_pending.push_back(CODE_F0);
            scan_pending.push_back(($urandom_range(0, 2) != 0) ? CODE_LCTRL
                                                               : 8'($urandom_range(0, 255)));
        end
        else if (pick < 86)
        begin
            scan_pending.push_back(CODE_E0);
            scan_pending.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            scan_pending.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    // Scan byte sender: bursts of random length separated by short random gaps.
    always @(negedge clk)
    begin
        if (rst_n && (!push || byte_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                push <= 1'b0;
                scan_byte <= 8'($urandom_range(0, 255));
            end
            else if (scan_pending.size() > 0)
            begin
                push <= 1'b1;
                scan_byte <= scan_pending.pop_front();
                if (burst_left > 1)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = $urandom_range(1, 48);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
            begin
                push <= 1'b0;
            end
        end
    end

    // Character reader: follows a stall pattern picked at random, then switches to another.
    always @(negedge clk)
    begin
        if (drain_left == 0)
        begin
            drain_mode = drain_mode_t'($urandom_range(0, 3));
            drain_left = $urandom_range(30, 200);
        end
        else
        begin
            drain_left--;
        end
        case (drain_mode)
            DRAIN_FREE:   pop <= 1'b1;
            DRAIN_COIN:   pop <= 1'($urandom_range(0, 1));
            DRAIN_SPARSE: pop <= ($urandom_range(0, 3) == 0);
            default:      pop <= (drain_left % 16 == 0);
        endcase
    end

    // Checks each character transfer, feeds each scan byte transfer to the model,
    // and stops the run when nothing moves for too long.
    always @(posedge clk)
    begin
        bit       char_taken;
        bit [6:0] want;
        if (rst_n)
        begin
            char_taken = pop && !empty;
            if (char_taken)
            begin
                if (chars_due.size() == 0)
                begin
                    report_mismatch($sformatf("char_code 0x%h with no character expected",
                                              char_code));
                end
                else
                begin
                    want = chars_due.pop_front();
                    if (char_code !== want)
                    begin
                        report_mismatch($sformatf("char_code 0x%h, expected 0x%h",
                                                  char_code, want));
                    end
                end
            end
            byte_taken = push && !full;
            if (byte_taken)
            begin
                predict_scan(scan_byte);
            end
            if (byte_taken || char_taken)
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired", $realtime);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        for (int c = 1; c < 256; c++)
        begin
            if (base_char(8'(c)) != 8'h00)
            begin
                key_codes.push_back(8'(c));
            end
        end

        // Directed opening: zero and unknown bytes, shift and caps, the shifted quote,
        // a caps release under control, control-P, control-2, right control on and off.
        scan_pending = '{8'h00, 8'hFF, 8'h1C, CODE_LSHIFT, 8'h52, CODE_F0, CODE_LSHIFT,
                         CODE_CAPS, CODE_LCTRL, CODE_F0, CODE_CAPS, 8'h4D, 8'h1E,
                         CODE_F0, CODE_LCTRL, CODE_E0, CODE_LCTRL, 8'h1C,
                         CODE_E0, CODE_F0, CODE_LCTRL, CODE_RSHIFT, CODE_CAPS,
                         CODE_BKSP, 8'h80};
        while (scan_pending.size() < SCAN_ITEMS)
        begin
            queue_key_event();
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for the last scan byte, then for the last character.
        while (scan_pending.size() != 0 || push)
        begin
            @(posedge clk);
        end
        while (chars_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (chars_due.size() != 0)
        begin
            report_mismatch($sformatf("%0d characters never arrived", chars_due.size()));
        end
        if (error_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
